FILE: rtl/core/alcm_pkg.sv
// Shared types and constants of the saturating lcm block.
`default_nettype none
package alcm_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int OUT_W       = 64;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [OUT_W-1:0]       out_word_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	localparam value_t VALUE_MASK = {VALUE_WIDTH{1'b1}};
	localparam cnt_t   CNT_LAST   = cnt_t'(VALUE_WIDTH - 1);

	typedef struct packed {
		logic [63:0] align_a;
		logic [63:0] align_b;
	} req_t;

	typedef struct packed {
		logic [63:0] common_alignment;
		logic        saturated;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic gcd_fin;
		logic div_step;
		logic mul_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic lo_zero;
		logic gcd_eq;
	} status_t;

endpackage
`default_nettype wire

FILE: rtl/core/alcm_datapath.sv
// Datapath: operand order, binary gcd, restoring divider, shift-add multiplier.
`default_nettype none
module alcm_datapath (
	input  wire logic             clk,
	input  wire alcm_pkg::req_t   req_data,
	input  wire alcm_pkg::cmd_t   cmd,
	output alcm_pkg::status_t     status,
	output alcm_pkg::rsp_t        rsp_data
);

	alcm_pkg::value_t hi_q, lo_q, a_q, b_q, g_q, r_q, n_q, acc_hi_q, acc_lo_q;
	alcm_pkg::cnt_t   k_q;
	logic             triv_q;
	alcm_pkg::rsp_t   out_q;

	alcm_pkg::value_t in_a, in_b, ord_hi, ord_lo;
	alcm_pkg::value_t a_minus_b, b_minus_a;
	logic [alcm_pkg::VALUE_WIDTH:0] div_shift, div_diff, mul_sum;
	logic             div_bit, prod_ovf;
	alcm_pkg::value_t prod_res;

	always_comb begin
		in_a = alcm_pkg::value_t'(req_data.align_a);
		in_b = alcm_pkg::value_t'(req_data.align_b);
		if (in_b > in_a) begin
			ord_hi = in_b;
			ord_lo = in_a;
		end else begin
			ord_hi = in_a;
			ord_lo = in_b;
		end
	end

	assign a_minus_b = a_q - b_q;
	assign b_minus_a = b_q - a_q;

	assign div_shift = {r_q, n_q[alcm_pkg::VALUE_WIDTH-1]};
	assign div_diff  = div_shift - {1'b0, g_q};
	assign div_bit   = ~div_diff[alcm_pkg::VALUE_WIDTH];

	assign mul_sum = {1'b0, acc_hi_q} + (n_q[0] ? {1'b0, hi_q} : '0);

	assign prod_ovf = |acc_hi_q;
	assign prod_res = prod_ovf ? alcm_pkg::VALUE_MASK : acc_lo_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hi_q   <= ord_hi;
			lo_q   <= ord_lo;
			a_q    <= ord_hi;
			b_q    <= ord_lo;
			k_q    <= '0;
			triv_q <= (ord_lo == '0);
		end
		if (cmd.gcd_step) begin
			// Stein step: strip twos, else subtract the smaller odd value
			priority if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + alcm_pkg::cnt_t'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= a_minus_b >> 1;
			end else begin
				b_q <= b_minus_a >> 1;
			end
		end
		if (cmd.gcd_fin) begin
			g_q      <= a_q << k_q;
			r_q      <= '0;
			n_q      <= lo_q;
			acc_hi_q <= '0;
		end
		if (cmd.div_step) begin
			r_q <= div_bit ? div_diff[alcm_pkg::VALUE_WIDTH-1:0]
			               : div_shift[alcm_pkg::VALUE_WIDTH-1:0];
			n_q <= {n_q[alcm_pkg::VALUE_WIDTH-2:0], div_bit};
		end
		if (cmd.mul_step) begin
			acc_hi_q <= mul_sum[alcm_pkg::VALUE_WIDTH:1];
			acc_lo_q <= {mul_sum[0], acc_lo_q[alcm_pkg::VALUE_WIDTH-1:1]};
			n_q      <= n_q >> 1;
		end
		if (cmd.out_load) begin
			if (triv_q) begin
				out_q.common_alignment <= alcm_pkg::out_word_t'(hi_q);
				out_q.saturated        <= 1'b0;
			end else begin
				out_q.common_alignment <= alcm_pkg::out_word_t'(prod_res);
				out_q.saturated        <= prod_ovf;
			end
		end
	end

	assign status.lo_zero = triv_q;
	assign status.gcd_eq  = (a_q == b_q);
	assign rsp_data       = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/alcm_ctrl.sv
// Controller: sequences load, gcd, divide, multiply and result hand-off.
`default_nettype none
module alcm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	input  wire alcm_pkg::status_t status,
	output alcm_pkg::cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_GCD    = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]     state_q, state_d;
	alcm_pkg::cnt_t cnt_q, cnt_d;
	logic           rsp_valid_q, out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = status.lo_zero ? ST_FINISH : ST_GCD;
			end
			ST_GCD: begin
				if (status.gcd_eq) begin
					cmd.gcd_fin = 1'b1;
					cnt_d       = '0;
					state_d     = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + alcm_pkg::cnt_t'(1);
				if (cnt_q == alcm_pkg::CNT_LAST) begin
					cnt_d   = '0;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + alcm_pkg::cnt_t'(1);
				if (cnt_q == alcm_pkg::CNT_LAST) begin
					cnt_d   = '0;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/alignment_lcm_saturating_top.sv
// Top level of the saturating lcm block: controller plus datapath.
//
// Usage: a request transaction on req_valid/req_ready carries align_a and
// align_b; one response transaction on rsp_valid/rsp_ready returns
// common_alignment and the saturated flag. Both values are unsigned; only
// the low VALUE_WIDTH bits are used.
// One request is in flight at a time. req_ready is high only while the
// controller is idle. A request with a zero operand skips gcd, divide and
// multiply. Otherwise the binary gcd runs until both values are equal, the
// restoring divider forms smaller/gcd, and the shift-add multiplier forms
// larger*(smaller/gcd), saturating to all ones on overflow.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, a finished second result waits in the
// controller until the output register frees up.
// Reset (arst_n low) returns the controller to idle and drops any pending
// response; no memory needs clearing.
`default_nettype none
module alignment_lcm_saturating_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire alcm_pkg::req_t req_data,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output alcm_pkg::rsp_t      rsp_data
);

	alcm_pkg::cmd_t    cmd;
	alcm_pkg::status_t status;

	alcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	alcm_datapath u_datapath (
		.clk      (clk),
		.req_data (req_data),
		.cmd      (cmd),
		.status   (status),
		.rsp_data (rsp_data)
	);

	// a new transaction cannot be taken directly after one is accepted
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.saturated |->
			rsp_data.common_alignment == alcm_pkg::out_word_t'(alcm_pkg::VALUE_MASK))
		else $error("saturated result is not all ones");

	a_load_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !cmd.load && !cmd.mul_step && !cmd.div_step)
		else $error("result load overlaps datapath work");

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for the saturating lcm block: queued driver, monitor and lcm predictor.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM    = 1150;
	localparam int QUIET_FIRST = 500;
	localparam int QUIET_LAST  = 700;
	localparam int DRAIN_CYCLES = 300;
	localparam int PROD_W      = 2 * alcm_pkg::VALUE_WIDTH;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	alcm_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	alcm_pkg::rsp_t rsp_data;

	alcm_pkg::req_t pending_req[$];
	alcm_pkg::rsp_t lcm_expected[$];
	int   n_accepted = 0;
	int   n_results = 0;
	int   n_saturated = 0;
	int   n_zero_operand = 0;
	int   mismatches = 0;

	alignment_lcm_saturating_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Order the pair, run Euclid, then test the exact double-width product.
	function automatic alcm_pkg::rsp_t lcm_predict(alcm_pkg::req_t r);
		alcm_pkg::value_t big, little, t, rem, g, q;
		logic [PROD_W-1:0] prod;
		alcm_pkg::rsp_t e;
		big = alcm_pkg::value_t'(r.align_a);
		little = alcm_pkg::value_t'(r.align_b);
		e = '0;
		if (little > big) begin
			t = big;
			big = little;
			little = t;
		end
		if (little == '0) begin
			e.common_alignment = big;
		end else begin
			g = big;
			t = little;
			while (t != '0) begin
				rem = g % t;
				g = t;
				t = rem;
			end
			q = little / g;
			prod = PROD_W'(big) * PROD_W'(q);
			if (prod[PROD_W-1:alcm_pkg::VALUE_WIDTH] != '0) begin
				e.common_alignment = alcm_pkg::VALUE_MASK;
				e.saturated = 1'b1;
			end else begin
				e.common_alignment = prod[alcm_pkg::VALUE_WIDTH-1:0];
			end
		end
		return e;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_sized(int unsigned max_bits);
		return rand64() >> (64 - $urandom_range(1, max_bits));
	endfunction

	// Hold both sides busy through a window of transactions, else idle ~20%.
	function automatic bit idle_roll();
		if (n_accepted >= QUIET_FIRST && n_accepted < QUIET_LAST)
			return 1'b0;
		return $urandom_range(0, 99) < 20;
	endfunction

	task automatic queue_pair(input logic [63:0] a, input logic [63:0] b);
		alcm_pkg::req_t r;
		r.align_a = a;
		r.align_b = b;
		pending_req.push_back(r);
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		$display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
	endtask

	// Stimulus: directed corners first, then random pairs.
	initial begin
		logic [63:0] a, b, g;
		int kind;
		queue_pair(64'h0, 64'h0);
		queue_pair(64'h0, 64'h1234_5678_9ABC_DEF0);
		queue_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
		queue_pair(64'h1, 64'h1);
		queue_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h1);
		queue_pair(64'h1, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
		// exact fit at all ones: coprime factors of 2^64-1
		queue_pair(64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0001);
		queue_pair(64'h0000_0001_0000_0000, 64'h0000_0001_0000_0001);
		queue_pair(64'h8000_0000_0000_0000, 64'h2);
		queue_pair(64'h8000_0000_0000_0000, 64'h3);
		queue_pair(64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000);
		queue_pair(64'h0000_0000_0000_0040, 64'h0000_0000_0000_1000);
		queue_pair(64'd12, 64'd18);
		queue_pair(64'd18, 64'd12);
		queue_pair(64'd1000000007, 64'd998244353);
		queue_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		queue_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		queue_pair(64'hDEAD_BEEF_0000_0000, 64'hDEAD_BEEF_0000_0000);
		queue_pair(64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFE);
		queue_pair(64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF);
		for (int i = 0; i < N_RANDOM; i++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					a = rand64();
					b = rand64();
				end
				1: begin
					a = rand_sized(64);
					b = rand_sized(64);
				end
				2, 3: begin
					// shared odd factor so the gcd is usually nontrivial
					g = rand_sized(24) | 64'h1;
					a = g * rand_sized(24);
					b = g * rand_sized(24);
				end
				4: begin
					a = rand_sized(16) << $urandom_range(0, 47);
					b = rand_sized(16) << $urandom_range(0, 47);
				end
				5: begin
					a = ($urandom_range(0, 3) == 0) ? 64'h0 : rand_sized(64);
					b = ($urandom_range(0, 1) == 0) ? 64'h0 : rand_sized(64);
					if ($urandom_range(0, 1)) {a, b} = {b, a};
				end
				6: begin
					a = rand_sized(40);
					b = a * rand_sized(24);
					if ($urandom_range(0, 1)) {a, b} = {b, a};
				end
				default: begin
					a = rand_sized(32);
					b = rand_sized(32);
				end
			endcase
			queue_pair(a, b);
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: refill the request slot once the current transaction has gone.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_ready) begin
				if (req_valid) begin
					lcm_expected.push_back(lcm_predict(req_data));
					n_accepted++;
					if (req_data.align_a == '0 || req_data.align_b == '0)
						n_zero_operand++;
				end
				if (pending_req.size() > 0 && !idle_roll()) begin
					req_data <= pending_req.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each response transaction against the oldest prediction.
	always @(posedge clk) begin
		alcm_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (lcm_expected.size() == 0) begin
					report("unexpected response", rsp_data.common_alignment, 64'h0);
				end else begin
					want = lcm_expected.pop_front();
					n_results++;
					if (want.saturated)
						n_saturated++;
					if (rsp_data.common_alignment !== want.common_alignment)
						report("common_alignment", rsp_data.common_alignment,
							want.common_alignment);
					if (rsp_data.saturated !== want.saturated)
						report("saturated", 64'(rsp_data.saturated), 64'(want.saturated));
				end
			end
			rsp_ready <= !idle_roll();
		end
	end

	initial begin
		@(posedge arst_n);
		while (pending_req.size() > 0 || req_valid || lcm_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d lcm results (%0d saturated, %0d with a zero operand).",
			n_results, n_saturated, n_zero_operand);
		$display("Mismatches found: %0d", mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3000000;
		$display("Timed out with %0d responses outstanding", lcm_expected.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

FILE: alignment_lcm_saturating_top.f
rtl/core/alcm_pkg.sv
rtl/core/alcm_datapath.sv
rtl/core/alcm_ctrl.sv
rtl/core/alignment_lcm_saturating_top.sv
test/tb.sv
